[hw/rtl/assert_macros.svh]
// Assertion macros shared by the websocket frame decoder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk_i, rst_n_i, pre, post) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (pre) |-> (post)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk_i, rst_n_i, pre, post) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (pre) |=> (post)) \
		else $error("next-cycle implication failed");

`endif

[hw/rtl/wsfd_pkg.sv]
// Shared types and constants for the websocket frame decoder.
// No dependencies.
package wsfd_pkg;

	localparam int LEN_BITS_DEF = 32;

	// 7-bit length codes in the second header byte
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	typedef struct packed {
		logic       too_big;
		logic       empty_frame;
		logic       last_of_frame;
		logic [3:0] frame_opcode;
		logic [7:0] payload_byte;
	} wsfd_result_t;

endpackage

[hw/rtl/wsfd_parser.sv]
// Frame header/payload parser with the deframing state; at most one result per byte.
// Depends on wsfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsfd_parser #(
	parameter int LEN_BITS = wsfd_pkg::LEN_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            rx_byte,
	output logic                  res_valid,
	output wsfd_pkg::wsfd_result_t res
);
	import wsfd_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR0, PH_HDR1, PH_EXT16, PH_EXT64, PH_KEY, PH_PAYLOAD
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [2:0]            cnt_q, cnt_d;
	logic [3:0]            opcode_q, opcode_d;
	logic                  masked_q, masked_d;
	logic                  big_q, big_d;
	logic [LEN_BITS-1:0]   rem_q, rem_d;
	logic [31:0]           key_q, key_d;
	logic [1:0]            kidx_q, kidx_d;

	logic                  emit;
	logic                  finish_len;
	logic                  start_pay;
	logic                  big_now;
	logic [LEN_BITS-1:0]   len_val;
	logic [LEN_BITS+7:0]   shifted;
	logic [7:0]            kbyte;

	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		opcode_d   = opcode_q;
		masked_d   = masked_q;
		big_d      = big_q;
		rem_d      = rem_q;
		key_d      = key_q;
		kidx_d     = kidx_q;
		emit       = 1'b0;
		finish_len = 1'b0;
		start_pay  = 1'b0;
		len_val    = rem_q;
		big_now    = big_q;
		kbyte      = 8'h00;
		shifted    = {rem_q, rx_byte};
		res.payload_byte  = 8'h00;
		res.frame_opcode  = opcode_q;
		res.last_of_frame = 1'b0;
		res.empty_frame   = 1'b0;
		res.too_big       = 1'b0;

		unique case (phase_q)
			PH_HDR0: begin
				opcode_d = rx_byte[3:0];
				phase_d  = PH_HDR1;
			end
			PH_HDR1: begin
				masked_d = rx_byte[7];
				big_d    = 1'b0;
				rem_d    = '0;
				key_d    = '0;
				cnt_d    = '0;
				if (rx_byte[6:0] == LEN_CODE_EXT16) begin
					phase_d = PH_EXT16;
				end else if (rx_byte[6:0] == LEN_CODE_EXT64) begin
					phase_d = PH_EXT64;
				end else begin
					finish_len = 1'b1;
					len_val    = LEN_BITS'(rx_byte[6:0]);
				end
			end
			PH_EXT16: begin
				len_val = LEN_BITS'({rem_q[7:0], rx_byte});
				rem_d   = len_val;
				cnt_d   = cnt_q + 3'd1;
				if (cnt_q == 3'd1) begin
					finish_len = 1'b1;
				end
			end
			PH_EXT64: begin
				// upper four bytes only flag; lower four shift in, bits pushed past
				// LEN_BITS mean the length does not fit
				if (cnt_q < 3'd4) begin
					big_now = big_q | (rx_byte != 8'h00);
				end else begin
					rem_d   = shifted[LEN_BITS-1:0];
					big_now = big_q | (shifted[LEN_BITS+7:LEN_BITS] != 8'h00);
				end
				len_val = rem_d;
				big_d   = big_now;
				if (cnt_q != 3'd7) begin
					cnt_d = cnt_q + 3'd1;
				end else begin
					cnt_d = '0;
					if (big_now) begin
						phase_d     = PH_HDR0;
						rem_d       = '0;
						emit        = 1'b1;
						res.last_of_frame = 1'b1;
						res.too_big       = 1'b1;
					end else begin
						finish_len = 1'b1;
					end
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], rx_byte};
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'd3) begin
					cnt_d     = '0;
					start_pay = 1'b1;
					len_val   = rem_q;
				end
			end
			PH_PAYLOAD: begin
				case (kidx_q)
					2'd0:    kbyte = key_q[31:24];
					2'd1:    kbyte = key_q[23:16];
					2'd2:    kbyte = key_q[15:8];
					default: kbyte = key_q[7:0];
				endcase
				if (!masked_q) begin
					kbyte = 8'h00;
				end
				kidx_d = kidx_q + 2'd1;
				rem_d  = rem_q - LEN_BITS'(1);
				emit   = 1'b1;
				res.payload_byte  = rx_byte ^ kbyte;
				res.last_of_frame = (rem_q == LEN_BITS'(1));
				if (rem_q == LEN_BITS'(1)) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				phase_d = PH_HDR0;
			end
		endcase

		// length is kept across the key bytes
		if (finish_len) begin
			cnt_d = '0;
			rem_d = len_val;
			if (masked_d) begin
				phase_d = PH_KEY;
			end else begin
				start_pay = 1'b1;
			end
		end

		if (start_pay) begin
			kidx_d = '0;
			rem_d  = len_val;
			if (len_val == '0) begin
				phase_d           = PH_HDR0;
				emit              = 1'b1;
				res.last_of_frame = 1'b1;
				res.empty_frame   = 1'b1;
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end
	end

	assign res_valid = fire & emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			cnt_q    <= '0;
			opcode_q <= '0;
			masked_q <= 1'b0;
			big_q    <= 1'b0;
			rem_q    <= '0;
			key_q    <= '0;
			kidx_q   <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			opcode_q <= opcode_d;
			masked_q <= masked_d;
			big_q    <= big_d;
			rem_q    <= rem_d;
			key_q    <= key_d;
			kidx_q   <= kidx_d;
		end
	end

	`ASSERT_IMPLIES(a_payload_len_nonzero, clk, arst_n, phase_q == PH_PAYLOAD, rem_q != '0)
	`ASSERT_IMPLIES(a_ext16_count, clk, arst_n, phase_q == PH_EXT16, cnt_q < 3'd2)
	`ASSERT_IMPLIES(a_hdr0_count_clear, clk, arst_n, phase_q == PH_HDR0, cnt_q == 3'd0)

endmodule

[hw/rtl/wsfd_out_buf.sv]
// Result output register with one skid entry, so the parser keeps taking bytes
// while a result waits. Depends on wsfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsfd_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  wsfd_pkg::wsfd_result_t in_res,
	output logic                   space,
	output logic                   out_valid,
	input  logic                   out_ready,
	output wsfd_pkg::wsfd_result_t out_res
);
	import wsfd_pkg::*;

	logic         out_v_q;
	logic         skid_v_q;
	wsfd_result_t out_q;
	wsfd_result_t skid_q;
	logic         advance;

	assign space     = ~skid_v_q;
	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign advance   = ~out_v_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (advance) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_valid;
			end
		end else if (in_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (in_valid) begin
				out_q <= in_res;
			end
		end else if (in_valid) begin
			skid_q <= in_res;
		end
	end

	`ASSERT_IMPLIES(a_skid_needs_out, clk, arst_n, skid_v_q, out_v_q)
	`ASSERT_NEXT(a_skid_moves_up, clk, arst_n, skid_v_q && out_ready, out_v_q)

endmodule

[hw/rtl/websocket_frame_decoder.sv]
// WebSocket frame decoder top level: stream ports around the parser and output buffer.
// Depends on wsfd_pkg, wsfd_parser and wsfd_out_buf.
//
// Takes one received stream byte per clock while s_tready is high and returns one
// result transaction per payload byte, one for a zero-length frame and one for an
// oversized 64-bit length. Every byte is decided in the cycle it is accepted by the
// parser state registers; its result leaves from the output register.
// A one-entry skid behind that register keeps s_tready high while a single result
// is stalled, so the sustained rate is one byte per cycle whenever m_tready keeps up.
module websocket_frame_decoder #(
	parameter int LEN_BITS = wsfd_pkg::LEN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] payload_byte, [11:8] frame_opcode, [15:12] zero
	output logic        m_tlast,   // last_of_frame
	output logic [1:0]  m_tuser    // [0] empty_frame, [1] too_big
);
	import wsfd_pkg::*;

	logic         fire;
	logic         res_valid;
	wsfd_result_t res;
	wsfd_result_t out_res;
	logic         space;

	assign s_tready = space;
	assign fire     = s_tvalid & space;

	wsfd_parser #(
		.LEN_BITS(LEN_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.rx_byte  (s_tdata),
		.res_valid(res_valid),
		.res      (res)
	);

	wsfd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_res   (res),
		.space    (space),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	assign m_tdata = {4'h0, out_res.frame_opcode, out_res.payload_byte};
	assign m_tlast = out_res.last_of_frame;
	assign m_tuser = {out_res.too_big, out_res.empty_frame};

endmodule

[dv/tb_websocket_frame_decoder.sv]
// Testbench for websocket_frame_decoder: directed byte table, then random frames with stalls.
// Depends on wsfd_pkg and the decoder RTL; results are checked against a local deframing model.
module tb_websocket_frame_decoder;
	import wsfd_pkg::*;

	localparam int LEN_LIMIT = LEN_BITS_DEF;
	localparam int RANDOM_BYTES = 1350;
	localparam int PAUSE_AT = 700;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 16;

	typedef enum logic [2:0] {
		PH_OPCODE, PH_LEN7, PH_LEN16, PH_LEN64, PH_KEY, PH_DATA
	} deframe_phase_t;

	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_mode_t;

	typedef struct packed {
		logic [7:0]   rx;
		logic         typed;
		wsfd_result_t want;
	} dir_row_t;

	localparam wsfd_result_t NO_RES = '0;

	// want fields: too_big, empty_frame, last_of_frame, frame_opcode, payload_byte
	localparam dir_row_t DIR_ROWS [23] = '{
		'{8'h8F, 1'b0, NO_RES},                               // FIN + opcode F
		'{8'h00, 1'b1, '{1'b0, 1'b1, 1'b1, 4'hF, 8'h00}},     // empty, unmasked
		'{8'h01, 1'b0, NO_RES},
		'{8'h80, 1'b0, NO_RES},                               // masked, length 0
		'{8'hFF, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES},
		'{8'hFF, 1'b1, '{1'b0, 1'b1, 1'b1, 4'h1, 8'h00}},     // empty after key
		'{8'hF2, 1'b0, NO_RES},                               // reserved bits set
		'{8'h7F, 1'b0, NO_RES},                               // 64-bit length
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h01, 1'b0, NO_RES},                               // upper half nonzero
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b1, '{1'b1, 1'b0, 1'b1, 4'h2, 8'h00}},     // oversized, dropped
		'{8'h0A, 1'b0, NO_RES},
		'{8'h7E, 1'b0, NO_RES},                               // non-minimal 16-bit length
		'{8'h00, 1'b0, NO_RES},
		'{8'h01, 1'b0, NO_RES},
		'{8'hFF, 1'b1, '{1'b0, 1'b0, 1'b1, 4'hA, 8'hFF}}      // single unmasked byte
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;

	// deframing model state
	deframe_phase_t dec_phase = PH_OPCODE;
	logic [2:0]     hdr_cnt = '0;
	logic [3:0]     cur_opcode = '0;
	logic           key_on = 1'b0;
	logic           upper_nz = 1'b0;
	logic [31:0]    len_left = '0;
	logic [31:0]    key_word = '0;
	logic [1:0]     key_pos = '0;

	wsfd_result_t awaited_results [$];
	int           bytes_sent = 0;
	int           burst_left = 0;
	int           mismatches = 0;
	int           cycles = 0;
	bit           paused = 1'b0;
	rx_mode_t     rx_mode = RX_OPEN;
	int           rx_left = 0;

	websocket_frame_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic wsfd_result_t make_result(input logic [7:0] p, input logic l, e, big);
		return '{too_big: big, empty_frame: e, last_of_frame: l, frame_opcode: cur_opcode,
			payload_byte: p};
	endfunction

	function automatic bit begin_payload(output wsfd_result_t r);
		key_pos = '0;
		r = '0;
		if (len_left == 0) begin
			dec_phase = PH_OPCODE;
			r = make_result(8'h00, 1'b1, 1'b1, 1'b0);
			return 1'b1;
		end
		dec_phase = PH_DATA;
		return 1'b0;
	endfunction

	function automatic bit length_complete(output wsfd_result_t r);
		hdr_cnt = '0;
		r = '0;
		if (key_on) begin
			dec_phase = PH_KEY;
			return 1'b0;
		end
		return begin_payload(r);
	endfunction

	// Advances the model by one stream byte; returns 1 when the byte yields a result.
	function automatic bit deframe_byte(input logic [7:0] b, output wsfd_result_t r);
		logic [7:0] k;
		r = '0;
		case (dec_phase)
		PH_LEN7: begin
			key_on = b[7];
			upper_nz = 1'b0;
			len_left = '0;
			key_word = '0;
			hdr_cnt = '0;
			if (b[6:0] == LEN_CODE_EXT16) begin
				dec_phase = PH_LEN16;
				return 1'b0;
			end
			if (b[6:0] == LEN_CODE_EXT64) begin
				dec_phase = PH_LEN64;
				return 1'b0;
			end
			len_left = 32'(b[6:0]);
			return length_complete(r);
		end
		PH_LEN16: begin
			len_left = {16'h0, len_left[7:0], b};
			hdr_cnt++;
			if (hdr_cnt < 2)
				return 1'b0;
			return length_complete(r);
		end
		PH_LEN64: begin
			if (hdr_cnt < 4) begin
				if (b != 0)
					upper_nz = 1'b1;
			end else begin
				len_left = {len_left[23:0], b};
			end
			if (hdr_cnt < 7) begin
				hdr_cnt++;
				return 1'b0;
			end
			hdr_cnt = '0;
			if (upper_nz || ((64'(len_left) >> LEN_LIMIT) != 0)) begin
				dec_phase = PH_OPCODE;
				len_left = '0;
				r = make_result(8'h00, 1'b1, 1'b0, 1'b1);
				return 1'b1;
			end
			return length_complete(r);
		end
		PH_KEY: begin
			key_word = {key_word[23:0], b};
			hdr_cnt++;
			if (hdr_cnt < 4)
				return 1'b0;
			hdr_cnt = '0;
			return begin_payload(r);
		end
		PH_DATA: begin
			// key byte 0 sits in the top bits of the key word
			k = key_on ? key_word[24 - 8 * key_pos +: 8] : 8'h00;
			key_pos++;
			len_left--;
			if (len_left == 0)
				dec_phase = PH_OPCODE;
			r = make_result(b ^ k, len_left == 0, 1'b0, 1'b0);
			return 1'b1;
		end
		default: begin
			cur_opcode = b[3:0];
			dec_phase = PH_LEN7;
			return 1'b0;
		end
		endcase
	endfunction

	// Presents one byte, honoring the burst/gap pattern, and records its expected result.
	task automatic push_byte(input logic [7:0] rx, input bit typed, input wsfd_result_t want);
		wsfd_result_t got;
		bit has;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rx;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		bytes_sent++;
		has = deframe_byte(rx, got);
		if (typed) begin
			has = 1'b1;
			got = want;
		end
		if (has)
			awaited_results.push_back(got);
	endtask

	// One random frame; sometimes a stray byte or a frame cut short, then realign.
	task automatic send_frame();
		logic [7:0]  fb [$];
		logic [7:0]  nb;
		logic [31:0] upper;
		logic [31:0] lower;
		bit          masked;
		bit          big;
		int          len;
		int          form;
		int          kind;
		int          cut;
		kind = $urandom_range(0, 15);
		if (kind == 0) begin
			push_byte(8'($urandom_range(0, 255)), 1'b0, NO_RES);
		end else begin
			masked = 1'($urandom_range(0, 1));
			big = 1'b0;
			form = $urandom_range(0, 9);
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(126, 300) : $urandom_range(0, 10);
			fb.push_back(8'($urandom_range(0, 255)));
			if (form < 6) begin
				if (len > 125)
					len = $urandom_range(0, 125);
				fb.push_back({masked, 7'(len)});
			end else if (form < 8) begin
				fb.push_back({masked, LEN_CODE_EXT16});
				fb.push_back(len[15:8]);
				fb.push_back(len[7:0]);
			end else begin
				big = ($urandom_range(0, 3) == 0);
				upper = big ? (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3))) : '0;
				lower = big ? $urandom : 32'(len);
				fb.push_back({masked, LEN_CODE_EXT64});
				for (int i = 3; i >= 0; i--)
					fb.push_back(upper[8 * i +: 8]);
				for (int i = 3; i >= 0; i--)
					fb.push_back(lower[8 * i +: 8]);
			end
			if (!big) begin
				if (masked)
					repeat (4) fb.push_back(8'($urandom_range(0, 255)));
				repeat (len) fb.push_back(8'($urandom_range(0, 255)));
			end
			cut = (kind == 1) ? $urandom_range(1, fb.size()) : fb.size();
			for (int i = 0; i < cut; i++)
				push_byte(fb[i], 1'b0, NO_RES);
		end
		// feed bytes that keep lengths short until the parser is back at a header
		while (dec_phase != PH_OPCODE) begin
			case (dec_phase)
			PH_LEN7: begin
				nb = 8'($urandom_range(0, 9));
				nb[7] = 1'($urandom_range(0, 1));
			end
			PH_LEN16, PH_LEN64: nb = 8'h00;
			default: nb = 8'($urandom_range(0, 255));
			endcase
			push_byte(nb, 1'b0, NO_RES);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// receiver backpressure, switching between patterns
	always @(posedge clk) begin
		if (rx_left != 0) begin
			rx_left <= rx_left - 1;
		end else begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(20, 120);
		end
		case (rx_mode)
		RX_OPEN:     m_tready <= 1'b1;
		RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
		RX_PERIODIC: m_tready <= (rx_left % 5 < 2);
		default:     m_tready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	always @(posedge clk) begin
		wsfd_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result transaction: tdata %h tlast %b tuser %b",
					m_tdata, m_tlast, m_tuser);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
				check_field("frame_opcode", 8'(want.frame_opcode), 8'(m_tdata[11:8]));
				check_field("tdata pad", 8'h00, 8'(m_tdata[15:12]));
				check_field("last_of_frame", 8'(want.last_of_frame), 8'(m_tlast));
				check_field("empty_frame", 8'(want.empty_frame), 8'(m_tuser[0]));
				check_field("too_big", 8'(want.too_big), 8'(m_tuser[1]));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(DIR_ROWS); i++)
			push_byte(DIR_ROWS[i].rx, DIR_ROWS[i].typed, DIR_ROWS[i].want);

		while (bytes_sent < $size(DIR_ROWS) + RANDOM_BYTES) begin
			// hold off once until the output side has fully drained
			if (!paused && bytes_sent > PAUSE_AT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (awaited_results.size() != 0)
					@(posedge clk);
				paused = 1'b1;
				burst_left = 0;
			end
			send_frame();
		end

		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
